[src/pad_gradient_accumulator_macros.svh]
// Assertion macros shared by the pad gradient accumulator checkers.
`ifndef PAD_GRADIENT_ACCUMULATOR_MACROS_SVH
`define PAD_GRADIENT_ACCUMULATOR_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define PGA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its cause.
`define PGA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/pga_pkg.sv]
// Shared types and constants of the pad gradient accumulator.
package pga_pkg;

   localparam int unsigned STORE_DEPTH_DEF = 4096;
   localparam int unsigned DATA_WIDTH_DEF  = 32;
   localparam int unsigned COORD_W         = 12;
   localparam int unsigned GRAD_W          = 32;
   localparam int unsigned CSR_DATA_W      = 36;
   localparam int unsigned CSR_INDEX_W     = 3;

   localparam logic [1:0] MODE_REFLECT  = 2'd0;
   localparam logic [1:0] MODE_EDGE     = 2'd1;
   localparam logic [1:0] MODE_CIRCULAR = 2'd2;

   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE,
      CSR_PAD_LEFT,
      CSR_PAD_RIGHT,
      CSR_PAD_TOP,
      CSR_PAD_BOTTOM,
      CSR_PAD_FRONT,
      CSR_PAD_BACK,
      CSR_OUT_SHAPE
   } csr_index_type;

   typedef struct packed {
      logic                     action;
      logic signed [GRAD_W-1:0] grad_value;
      logic [COORD_W-1:0]       plane;
      logic [COORD_W-1:0]       z_coord;
      logic [COORD_W-1:0]       y_coord;
      logic [COORD_W-1:0]       x_coord;
      logic [COORD_W-1:0]       read_index;
   } req_type;

   typedef struct packed {
      logic signed [GRAD_W-1:0] read_value;
      logic                     out_of_range;
      logic [COORD_W-1:0]       target_index;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                mode;
      logic signed [COORD_W-1:0] pad_left;
      logic signed [COORD_W-1:0] pad_right;
      logic signed [COORD_W-1:0] pad_top;
      logic signed [COORD_W-1:0] pad_bottom;
      logic signed [COORD_W-1:0] pad_front;
      logic signed [COORD_W-1:0] pad_back;
      logic [CSR_DATA_W-1:0]     out_shape;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FOLD,
      ST_MUL_Z,
      ST_MUL_Y,
      ST_MUL_X,
      ST_MEM_RD,
      ST_MEM_WR
   } state_type;

   typedef struct packed {
      logic load;
      logic fold;
      logic mul_z;
      logic mul_y;
      logic mul_x;
      logic mem_rd;
      logic mem_wr;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
   } sts_type;

endpackage

[src/pad_gradient_accumulator.sv]
// Top level of the pad gradient accumulator.
//
// Backward pass of reflect / edge / circular padding. Each word on the req_
// channel either adds a gradient value of the padded tensor into the
// accumulator store, at the address its coordinates fold back to, or reads
// one store entry and clears it.
// Request channel: a word is taken at a clock edge where start is high and
// busy is low. Result channel: rsp_valid strobes for one cycle per request
// word; the receiver cannot stall, so the result is simply presented once.
// Sequence: a read passes the read state, then the write back of zero; an add
// passes fold, three multiply-add steps through one shared multiplier, read,
// then the write back of the sum; the strobe is registered from the write back.
// busy drops in the cycle the strobe shows, so the next word is taken at the
// edge that ends it; no new word is taken before then, as the address multiply
// chain, the store's single read-modify-write port and the registered strobe hold it.
// Reset (synchronous, active high) clears the configuration registers and
// then sweeps zeros through the store, one entry a cycle, with busy high. The
// csr_ port writes one register per cycle, no wait, and is meant to be used
// only while the block is idle.
module pad_gradient_accumulator
   import pga_pkg::*;
#(
   parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
   parameter int unsigned DATA_WIDTH  = DATA_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req,
   output logic                   rsp_valid,
   output rsp_type                rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   // hold configuration
   pga_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // advance the sequence: clear sweep, then one request word at a time
   pga_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req.action),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   // fold coordinates, build the address, update the store
   pga_datapath #(
      .STORE_DEPTH (STORE_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req),
      .cfg   (cfg),
      .sts   (sts),
      .rsp   (rsp)
   );

endmodule

[src/pga_csr.sv]
// Configuration registers of the pad gradient accumulator.
module pga_csr
   import pga_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE:       cfg_in.mode       = csr_wdata[1:0];
            CSR_PAD_LEFT:   cfg_in.pad_left   = csr_wdata[COORD_W-1:0];
            CSR_PAD_RIGHT:  cfg_in.pad_right  = csr_wdata[COORD_W-1:0];
            CSR_PAD_TOP:    cfg_in.pad_top    = csr_wdata[COORD_W-1:0];
            CSR_PAD_BOTTOM: cfg_in.pad_bottom = csr_wdata[COORD_W-1:0];
            CSR_PAD_FRONT:  cfg_in.pad_front  = csr_wdata[COORD_W-1:0];
            CSR_PAD_BACK:   cfg_in.pad_back   = csr_wdata[COORD_W-1:0];
            CSR_OUT_SHAPE:  cfg_in.out_shape  = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/pga_ctrl.sv]
// Sequencing state machine of the pad gradient accumulator.
module pga_ctrl
   import pga_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    req_action,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy,
   output logic    rsp_valid
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_action == ACT_READ) ? ST_MEM_RD : ST_FOLD;
            end
         end
         ST_FOLD:   state_in = ST_MUL_Z;
         ST_MUL_Z:  state_in = ST_MUL_Y;
         ST_MUL_Y:  state_in = ST_MUL_X;
         ST_MUL_X:  state_in = ST_MEM_RD;
         ST_MEM_RD: state_in = ST_MEM_WR;
         ST_MEM_WR: state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd          = '0;
      busy         = (state_ff != ST_IDLE);
      cmd.load     = accept;
      cmd.clear    = (state_ff == ST_CLEAR);
      cmd.fold     = (state_ff == ST_FOLD);
      cmd.mul_z    = (state_ff == ST_MUL_Z);
      cmd.mul_y    = (state_ff == ST_MUL_Y);
      cmd.mul_x    = (state_ff == ST_MUL_X);
      cmd.mem_rd   = (state_ff == ST_MEM_RD);
      cmd.mem_wr   = (state_ff == ST_MEM_WR);
      rsp_valid_in = (state_ff == ST_MEM_WR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[src/pga_datapath.sv]
// Coordinate folding, address build and accumulator store.
module pga_datapath
   import pga_pkg::*;
#(
   parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF,
   parameter int unsigned DATA_WIDTH  = DATA_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req,
   input  cfg_type cfg,
   output sts_type sts,
   output rsp_type rsp
);

   localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
   localparam int unsigned AW1    = $clog2(STORE_DEPTH + 1);
   localparam int unsigned PW     = AW1 + COORD_W + 1;
   localparam logic [PW-1:0] DEPTH_PW = PW'(STORE_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

   typedef struct packed {
      logic               bad;
      logic [COORD_W-1:0] idx;
   } fold_type;

   function automatic fold_type fold_axis(
      input logic [1:0]                mode,
      input logic [COORD_W-1:0]        n,
      input logic signed [COORD_W-1:0] b,
      input logic signed [COORD_W-1:0] e,
      input logic [COORD_W-1:0]        s
   );
      logic [1:0]         m;
      logic signed [15:0] ns;
      logic signed [15:0] bs;
      logic signed [15:0] es;
      logic signed [15:0] ss;
      logic signed [15:0] emin;
      logic signed [15:0] bmin;
      logic signed [15:0] r;
      fold_type           f;
      // unused mode code clamps like edge
      m    = (mode != MODE_REFLECT && mode != MODE_CIRCULAR) ? MODE_EDGE : mode;
      ns   = signed'({4'b0, n});
      bs   = signed'({{4{b[COORD_W-1]}}, b});
      es   = signed'({{4{e[COORD_W-1]}}, e});
      ss   = signed'({4'b0, s});
      emin = (es < 16'sd0) ? es : 16'sd0;
      bmin = (bs < 16'sd0) ? bs : 16'sd0;
      if (ns < bs) begin
         unique case (m)
            MODE_REFLECT:  r = bs - ns;
            MODE_CIRCULAR: r = ss + ns - bs + emin;
            default:       r = 16'sd0;
         endcase
      end else if (ns < ss + bs) begin
         r = ns - bs;
      end else begin
         unique case (m)
            MODE_REFLECT:  r = (ss <<< 1) + bs - 16'sd2 - ns;
            MODE_CIRCULAR: r = ns - ss - bs - bmin;
            default:       r = ss - 16'sd1;
         endcase
      end
      f.bad = (r < 16'sd0) || (r >= ss);
      f.idx = r[COORD_W-1:0];
      return f;
   endfunction

   logic [DATA_WIDTH-1:0] mem_q [STORE_DEPTH];

   req_type               req_ff;
   logic [COORD_W-1:0]    fx_ff, fy_ff, fz_ff;
   logic [COORD_W-1:0]    fx_in, fy_in, fz_in;
   logic [AW1-1:0]        acc_ff;
   logic [AW1-1:0]        acc_in;
   logic                  oor_ff;
   logic                  oor_in;
   logic [ADDR_W-1:0]     addr_ff;
   logic [ADDR_W-1:0]     addr_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [ADDR_W-1:0]     clr_cnt_ff;
   logic [ADDR_W-1:0]     clr_cnt_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   fold_type              fold_x, fold_y, fold_z;
   logic [COORD_W-1:0]    sw, sh, sd;
   logic [COORD_W-1:0]    mul_size;
   logic [COORD_W-1:0]    mul_idx;
   logic [AW1+COORD_W-1:0] mul_prod;
   logic [PW-1:0]         mul_sum;
   logic                  is_read;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  mem_we;
   logic [ADDR_W-1:0]     wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [63:0]           grad_ext;

   assign sw      = cfg.out_shape[COORD_W-1:0];
   assign sh      = cfg.out_shape[2*COORD_W-1:COORD_W];
   assign sd      = cfg.out_shape[3*COORD_W-1:2*COORD_W];
   assign is_read = (req_ff.action == ACT_READ);

   assign fold_x = fold_axis(cfg.mode, req_ff.x_coord, cfg.pad_left, cfg.pad_right, sw);
   assign fold_y = fold_axis(cfg.mode, req_ff.y_coord, cfg.pad_top, cfg.pad_bottom, sh);
   assign fold_z = fold_axis(cfg.mode, req_ff.z_coord, cfg.pad_front, cfg.pad_back, sd);

   // one shared multiply-add builds the flat address: acc = acc * size + index
   always_comb begin
      priority if (cmd.mul_z) begin
         mul_size = sd;
         mul_idx  = fz_ff;
      end else if (cmd.mul_y) begin
         mul_size = sh;
         mul_idx  = fy_ff;
      end else begin
         mul_size = sw;
         mul_idx  = fx_ff;
      end
   end

   assign mul_prod = acc_ff * mul_size;
   assign mul_sum  = {1'b0, mul_prod} + PW'(mul_idx);

   always_comb begin
      fx_in   = fx_ff;
      fy_in   = fy_ff;
      fz_in   = fz_ff;
      acc_in  = acc_ff;
      oor_in  = oor_ff;
      addr_in = addr_ff;
      if (cmd.fold) begin
         fx_in  = fold_x.idx;
         fy_in  = fold_y.idx;
         fz_in  = fold_z.idx;
         acc_in = AW1'(req_ff.plane);
         oor_in = fold_x.bad || fold_y.bad || fold_z.bad ||
                  (PW'(req_ff.plane) >= DEPTH_PW);
      end else if (cmd.mul_z || cmd.mul_y || cmd.mul_x) begin
         // once past the store the address only grows: keep the flag sticky
         acc_in = mul_sum[AW1-1:0];
         oor_in = oor_ff || (mul_sum >= DEPTH_PW);
      end else if (cmd.mem_rd) begin
         addr_in = rd_addr;
         if (is_read) begin
            oor_in = (PW'(req_ff.read_index) >= DEPTH_PW);
         end
      end
   end

   assign rd_addr = is_read ? ADDR_W'(req_ff.read_index) : acc_ff[ADDR_W-1:0];

   assign grad_ext   = {{(64 - GRAD_W){req_ff.grad_value[GRAD_W-1]}}, req_ff.grad_value};
   assign clr_cnt_in = clr_cnt_ff + ADDR_W'(1);

   always_comb begin
      mem_we  = cmd.clear || (cmd.mem_wr && !oor_ff);
      wr_addr = cmd.clear ? clr_cnt_ff : addr_ff;
      if (cmd.clear || is_read) begin
         wr_data = '0;
      end else begin
         wr_data = rd_data_ff + DATA_WIDTH'(grad_ext);
      end
   end

   always_comb begin
      rsp_in.read_value   = (is_read && !oor_ff) ? GRAD_W'(rd_data_ff) : '0;
      rsp_in.out_of_range = oor_ff;
      if (is_read) begin
         rsp_in.target_index = req_ff.read_index;
      end else begin
         rsp_in.target_index = oor_ff ? '0 : COORD_W'(addr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_q[wr_addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem_q[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
      end
      fx_ff   <= fx_in;
      fy_ff   <= fy_in;
      fz_ff   <= fz_in;
      acc_ff  <= acc_in;
      oor_ff  <= oor_in;
      addr_ff <= addr_in;
      if (cmd.mem_wr) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign sts.clear_done = (clr_cnt_ff == LAST_ADDR);
   assign rsp            = rsp_ff;

endmodule

[src/pga_checker.sv]
// Port-level checks of the pad gradient accumulator, bound to the top level.
`include "pad_gradient_accumulator_macros.svh"

module pga_checker
   import pga_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp
);

   `PGA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted word did not raise busy")
   `PGA_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid, "result strobe longer than one cycle")
   `PGA_ASSERT_SAME(a_strobe_idle, clock, reset, rsp_valid, !busy, "result strobe while busy")
   `PGA_ASSERT_SAME(a_oor_zero, clock, reset, rsp_valid && rsp.out_of_range, rsp.read_value == '0, "rejected word returned data")

endmodule

bind pad_gradient_accumulator pga_checker u_pga_checker (.*);

[tb/sv/tb_pad_gradient_accumulator.sv]
// Self-checking testbench of the pad gradient accumulator.
`timescale 1ns / 1ps

module tb_pad_gradient_accumulator;
   import pga_pkg::*;

   // Mode code three has no name in the package; the block treats it as edge.
   localparam logic [1:0] MODE_CLAMP_ALIAS = 2'd3;
   localparam int LIMIT_CYCLES = 250000;
   localparam int IDLE_TAIL    = 10;   // margin after the block has gone idle
   localparam int PHASE_WORDS  = 238;
   localparam int PHASES       = 6;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req;
   logic                   rsp_valid;
   rsp_type                rsp;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   pad_gradient_accumulator uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the block: accumulated gradients and the active register set.
   logic [GRAD_W-1:0] grad_mem [STORE_DEPTH_DEF];
   cfg_type           cur_cfg;

   rsp_type pending_rsp [$];    // expected result words, oldest first
   int      touched_addr [$];   // store entries that took an add

   int fail_count  = 0;
   int cycle_count = 0;
   int burst_left  = 0;
   int n_adds      = 0;
   int n_reads     = 0;
   int n_flagged   = 0;
   int n_settings  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run as failed if it runs too long, as when the block stops answering.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Fold one padded coordinate back onto its unpadded axis.
   function automatic longint fold_coord(longint n, longint b, longint e, longint s,
                                         logic [1:0] m);
      logic [1:0] eff;
      eff = (m == MODE_CLAMP_ALIAS) ? MODE_EDGE : m;
      if (n < b) begin
         case (eff)
            MODE_REFLECT: return b - n;
            MODE_EDGE:    return 0;
            default:      return s + n - b + ((e < 0) ? e : 0);
         endcase
      end
      if (n < s + b) return n - b;
      case (eff)
         MODE_REFLECT: return 2 * s + b - 2 - n;
         MODE_EDGE:    return s - 1;
         default:      return n - s - b - ((b < 0) ? b : 0);
      endcase
   endfunction

   // Work out the result word of one accepted word and update the shadow store.
   function automatic rsp_type accumulate_word(req_type w);
      rsp_type r;
      longint  sw, sh, sd, fx, fy, fz, addr;
      r = '0;
      if (w.action == ACT_READ) begin
         r.read_value   = grad_mem[w.read_index];
         r.target_index = w.read_index;
         grad_mem[w.read_index] = '0;
         return r;
      end
      sw = longint'(cur_cfg.out_shape[11:0]);
      sh = longint'(cur_cfg.out_shape[23:12]);
      sd = longint'(cur_cfg.out_shape[35:24]);
      fx = fold_coord(longint'(w.x_coord), longint'(cur_cfg.pad_left),
                      longint'(cur_cfg.pad_right), sw, cur_cfg.mode);
      fy = fold_coord(longint'(w.y_coord), longint'(cur_cfg.pad_top),
                      longint'(cur_cfg.pad_bottom), sh, cur_cfg.mode);
      fz = fold_coord(longint'(w.z_coord), longint'(cur_cfg.pad_front),
                      longint'(cur_cfg.pad_back), sd, cur_cfg.mode);
      // Flag folds that leave their axis (a zero-size axis always does).
      if (fx < 0 || fx >= sw || fy < 0 || fy >= sh || fz < 0 || fz >= sd) begin
         r.out_of_range = 1'b1;
         return r;
      end
      addr = ((longint'(w.plane) * sd + fz) * sh + fy) * sw + fx;
      // Flag flat addresses past the end of the store; leave it untouched.
      if (addr >= longint'(STORE_DEPTH_DEF)) begin
         r.out_of_range = 1'b1;
         return r;
      end
      grad_mem[addr]  = grad_mem[addr] + w.grad_value;   // wraps at 32 bits
      r.target_index  = addr[COORD_W-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Result checking: every strobed word against the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            $error("result word with nothing pending: read_value %0d, out_of_range %0b, target_index %0d",
                   rsp.read_value, rsp.out_of_range, rsp.target_index);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp.read_value !== want.read_value) begin
               $error("read_value: expected %0d, got %0d", want.read_value, rsp.read_value);
               fail_count++;
            end
            if (rsp.out_of_range !== want.out_of_range) begin
               $error("out_of_range: expected %0b, got %0b",
                      want.out_of_range, rsp.out_of_range);
               fail_count++;
            end
            if (rsp.target_index !== want.target_index) begin
               $error("target_index: expected %0d, got %0d",
                      want.target_index, rsp.target_index);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------

   // Present one word, hold it until the block takes it, then log the
   // expectation. Start stays high inside a burst; drop it for a random gap
   // when the burst runs out.
   task automatic send_word(input req_type w);
      rsp_type exp_r;
      start <= 1'b1;
      req   <= w;
      do @(posedge clock); while (busy !== 1'b0);
      exp_r = accumulate_word(w);
      pending_rsp.push_back(exp_r);
      if (w.action == ACT_ADD) begin
         n_adds++;
         if (!exp_r.out_of_range) touched_addr.push_back(int'(exp_r.target_index));
      end else begin
         n_reads++;
      end
      if (exp_r.out_of_range) n_flagged++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
         // Mostly short bursts, now and then a long stretch with no gaps.
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 6);
      end
   endtask

   task automatic add_word(input int p, input int z, input int y, input int x,
                           input logic [GRAD_W-1:0] g);
      req_type w;
      w            = '0;
      w.action     = ACT_ADD;
      w.grad_value = g;
      w.plane      = COORD_W'(p);
      w.z_coord    = COORD_W'(z);
      w.y_coord    = COORD_W'(y);
      w.x_coord    = COORD_W'(x);
      w.read_index = COORD_W'($urandom);
      send_word(w);
   endtask

   task automatic read_word(input int idx);
      req_type w;
      w            = '0;
      w.action     = ACT_READ;
      w.grad_value = $urandom;
      w.plane      = COORD_W'($urandom);
      w.z_coord    = COORD_W'($urandom);
      w.y_coord    = COORD_W'($urandom);
      w.x_coord    = COORD_W'($urandom);
      w.read_index = COORD_W'(idx);
      send_word(w);
   endtask

   // Drop start and wait until every expected word is in and the block is idle.
   task automatic settle_block();
      start <= 1'b0;
      while (pending_rsp.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (IDLE_TAIL) @(posedge clock);
   endtask

   // Register write data; junk in the unused upper bits must be ignored.
   function automatic logic [CSR_DATA_W-1:0] csr_word(cfg_type c, csr_index_type i);
      logic [63:0]           fill64;
      logic [CSR_DATA_W-1:0] d;
      fill64 = {$urandom, $urandom};
      d      = fill64[CSR_DATA_W-1:0];
      case (i)
         CSR_MODE:       d[1:0]         = c.mode;
         CSR_PAD_LEFT:   d[COORD_W-1:0] = c.pad_left;
         CSR_PAD_RIGHT:  d[COORD_W-1:0] = c.pad_right;
         CSR_PAD_TOP:    d[COORD_W-1:0] = c.pad_top;
         CSR_PAD_BOTTOM: d[COORD_W-1:0] = c.pad_bottom;
         CSR_PAD_FRONT:  d[COORD_W-1:0] = c.pad_front;
         CSR_PAD_BACK:   d[COORD_W-1:0] = c.pad_back;
         default:        d              = c.out_shape;
      endcase
      return d;
   endfunction

   // Write every register, one per cycle, once the block has gone idle.
   task automatic apply_cfg(input cfg_type c);
      csr_index_type idx;
      settle_block();
      for (int i = 0; i <= int'(CSR_OUT_SHAPE); i++) begin
         idx = csr_index_type'(i);
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= csr_word(c, idx);
         @(posedge clock);
      end
      csr_we  <= 1'b0;
      cur_cfg = c;
      n_settings++;
   endtask

   // ------------------------------------------------------------------
   // Random stimulus
   // ------------------------------------------------------------------

   // Pad mostly within one axis length either way, sometimes anything.
   function automatic logic [COORD_W-1:0] random_pad(int s);
      if ($urandom_range(0, 9) == 0) return COORD_W'($urandom);
      return COORD_W'(int'($urandom_range(0, 2 * s)) - s);
   endfunction

   function automatic cfg_type random_cfg(int axes, logic [1:0] m);
      cfg_type c;
      int      ws, hs, ds;
      c    = '0;
      c.mode = m;
      ws = $urandom_range(1, 9);
      hs = (axes >= 2) ? $urandom_range(1, 7) : 1;
      ds = (axes >= 3) ? $urandom_range(1, 5) : 1;
      c.pad_left  = random_pad(ws);
      c.pad_right = random_pad(ws);
      if (axes >= 2) begin
         c.pad_top    = random_pad(hs);
         c.pad_bottom = random_pad(hs);
      end
      if (axes >= 3) begin
         c.pad_front = random_pad(ds);
         c.pad_back  = random_pad(ds);
      end
      c.out_shape[11:0]  = COORD_W'(ws);
      c.out_shape[23:12] = COORD_W'(hs);
      c.out_shape[35:24] = COORD_W'(ds);
      return c;
   endfunction

   // Coordinate inside the padded axis, with the odd one anywhere.
   function automatic logic [COORD_W-1:0] pick_coord(longint s, longint b, longint e);
      longint span;
      span = s + b + e;
      if (span <= 0 || $urandom_range(0, 19) == 0) return COORD_W'($urandom_range(0, 4095));
      if (span > 4096) span = 4096;
      return COORD_W'($urandom_range(0, int'(span) - 1));
   endfunction

   function automatic req_type random_word();
      req_type w;
      int      pick;
      longint  sw, sh, sd, vol, plane_hi;
      pick         = $urandom_range(0, 99);
      w.action     = ACT_ADD;
      w.grad_value = $urandom;
      w.plane      = COORD_W'($urandom);
      w.z_coord    = COORD_W'($urandom);
      w.y_coord    = COORD_W'($urandom);
      w.x_coord    = COORD_W'($urandom);
      w.read_index = COORD_W'($urandom);
      if (pick < 55) begin
         // Well-formed add: coordinates mostly inside the padded tensor, plane up to the
         // store's end so that some adds land just past it.
         sw  = longint'(cur_cfg.out_shape[11:0]);
         sh  = longint'(cur_cfg.out_shape[23:12]);
         sd  = longint'(cur_cfg.out_shape[35:24]);
         vol = sw * sh * sd;
         plane_hi = (vol == 0) ? 0 : longint'(STORE_DEPTH_DEF) / vol;
         if (plane_hi > 4095) plane_hi = 4095;
         w.plane   = COORD_W'($urandom_range(0, int'(plane_hi)));
         w.x_coord = pick_coord(sw, longint'(cur_cfg.pad_left), longint'(cur_cfg.pad_right));
         w.y_coord = pick_coord(sh, longint'(cur_cfg.pad_top), longint'(cur_cfg.pad_bottom));
         w.z_coord = pick_coord(sd, longint'(cur_cfg.pad_front), longint'(cur_cfg.pad_back));
         case ($urandom_range(0, 11))
            0:       w.grad_value = 32'h7FFF_FFFF;
            1:       w.grad_value = 32'h8000_0000;
            2:       w.grad_value = '1;
            3:       w.grad_value = $urandom_range(0, 15);
            default: ;
         endcase
      end else if (pick < 85) begin
         // Read back mostly entries that took adds.
         w.action = ACT_READ;
         if (touched_addr.size() != 0)
            w.read_index = COORD_W'(touched_addr[$urandom_range(0, touched_addr.size() - 1)]);
      end else begin
         w.action = 1'($urandom_range(0, 1));
      end
      return w;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Right after reset: cleared store, zero shape folds everything out.
   task automatic test_reset_state();
      read_word(0);
      read_word(STORE_DEPTH_DEF - 1);
      add_word(0, 0, 0, 0, 32'h0000_0001);
   endtask

   // Before and after corners in every mode, including the unnamed code.
   task automatic test_fold_modes();
      logic [1:0] mode_codes [4];
      cfg_type    c;
      mode_codes = '{MODE_REFLECT, MODE_EDGE, MODE_CIRCULAR, MODE_CLAMP_ALIAS};
      foreach (mode_codes[k]) begin
         c            = '0;
         c.mode       = mode_codes[k];
         c.pad_left   = COORD_W'(2);
         c.pad_right  = COORD_W'(1);
         c.pad_top    = COORD_W'(1);
         c.pad_bottom = COORD_W'(-1);   // crop the last row
         c.pad_front  = COORD_W'(1);
         c.pad_back   = COORD_W'(0);
         c.out_shape  = {12'd2, 12'd3, 12'd4};
         apply_cfg(c);
         add_word(1, 0, 0, 0, $urandom);
         add_word(0, 2, 2, 6, $urandom);
         read_word((touched_addr.size() != 0) ? touched_addr[$] : 0);
      end
   endtask

   // Single-entry tensor: everything clamps onto entry zero; sums wrap.
   task automatic test_wraparound();
      cfg_type c;
      c           = '0;
      c.mode      = MODE_EDGE;
      c.out_shape = {12'd1, 12'd1, 12'd1};
      apply_cfg(c);
      add_word(0, 0, 0, 0, 32'h7FFF_FFFF);
      add_word(0, 4095, 4095, 4095, 32'h7FFF_FFFF);
      add_word(0, 0, 0, 0, 32'h8000_0000);
      read_word(0);
      add_word(0, 0, 0, 0, '1);
      read_word(0);
   endtask

   // Extreme pads and shape, then a reflect pad wider than its axis.
   task automatic test_range_limits();
      cfg_type c;
      c            = '0;
      c.mode       = MODE_CIRCULAR;
      c.pad_left   = COORD_W'(-2048);
      c.pad_right  = COORD_W'(2047);
      c.pad_top    = COORD_W'(2047);
      c.pad_bottom = COORD_W'(-2048);
      c.pad_front  = COORD_W'(-2048);
      c.pad_back   = COORD_W'(2047);
      c.out_shape  = '1;
      apply_cfg(c);
      add_word(4095, 4095, 4095, 4095, 32'h8000_0000);
      add_word(0, 0, 0, 0, 32'h7FFF_FFFF);
      c           = '0;
      c.mode      = MODE_REFLECT;
      c.pad_left  = COORD_W'(5);
      c.out_shape = {12'd1, 12'd1, 12'd2};
      apply_cfg(c);
      add_word(0, 0, 0, 0, $urandom);
      read_word(STORE_DEPTH_DEF - 1);
   endtask

   // Random words under a series of settings: one axis, two axes, then three.
   task automatic test_random_phases();
      int         axes;
      logic [1:0] m;
      for (int ph = 0; ph < PHASES; ph++) begin
         axes = (ph == 0) ? 1 : (ph == 1) ? 2 : 3;
         m    = (ph < 4) ? ph[1:0] : 2'($urandom_range(0, 3));
         apply_cfg(random_cfg(axes, m));
         repeat (PHASE_WORDS) send_word(random_word());
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      foreach (grad_mem[i]) grad_mem[i] = '0;
      cur_cfg   = '0;
      reset     <= 1'b1;
      start     <= 1'b0;
      req       <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_MODE;
      csr_wdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_fold_modes();
      test_wraparound();
      test_range_limits();
      test_random_phases();
      settle_block();

      if (pending_rsp.size() != 0) begin
         $error("%0d expected result words never arrived", pending_rsp.size());
         fail_count++;
      end
      $display("Covered %0d adds and %0d reads, %0d of them flagged out of range,",
               n_adds, n_reads, n_flagged);
      $display("under %0d register settings across all four mode codes.", n_settings);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
